/* rtl/core/console_line_editor_defines.svh */
// Assertion helpers used by the console line editor controller RTL.
`ifndef CONSOLE_LINE_EDITOR_DEFINES_SVH
`define CONSOLE_LINE_EDITOR_DEFINES_SVH

// Condition that must hold at every clock edge out of reset.
`define CLE_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) else $error(msg);

// Consequent that must hold in the same cycle as the antecedent.
`define CLE_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) else $error(msg);

`endif

/* rtl/core/cle_pkg.sv */
`timescale 1ns / 1ps
package cle_pkg;

    // Default line store depth.
    localparam int LINE_LEN_DEF = 64;

    // Console control characters.
    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_EOT  = 8'h04;
    localparam logic [7:0] CH_BS   = 8'h08;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_KILL = 8'h15;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD,
        ST_EMPTY
    } cle_state_t;

endpackage

/* rtl/core/cle_line_ram.sv */
`timescale 1ns / 1ps
module cle_line_ram #(
    parameter int LINE_LEN = cle_pkg::LINE_LEN_DEF,
    parameter int IDX_W    = $clog2(LINE_LEN)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  logic [7:0]       wr_data,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output logic [7:0]       rd_data
);

    logic [7:0] mem [LINE_LEN];
    logic [7:0] rd_data_reg;

    // Single write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port; the data holds until the next read.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/cle_ctrl.sv */
`timescale 1ns / 1ps
`include "console_line_editor_defines.svh"
module cle_ctrl #(
    parameter int LINE_LEN = cle_pkg::LINE_LEN_DEF,
    parameter int IDX_W    = $clog2(LINE_LEN),
    parameter int CNT_W    = $clog2(LINE_LEN + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic             cfg_wdata,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       in_char,
    input  logic             in_pend,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,
    output logic             m_tlast,
    output logic             m_tuser,
    output logic             ram_we,
    output logic [IDX_W-1:0] ram_waddr,
    output logic [7:0]       ram_wdata,
    output logic             ram_re,
    output logic [IDX_W-1:0] ram_raddr,
    input  logic [7:0]       ram_rdata
);
    import cle_pkg::*;

    cle_state_t       state_reg, state_next;
    logic             raw_mode_reg;
    logic [CNT_W-1:0] fill_count_reg, fill_count_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0] last_idx_reg, last_idx_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [7:0]       m_tdata_reg;
    logic             m_tlast_reg;
    logic             m_tuser_reg;

    logic             accept;
    logic             slot_free;
    logic             at_last;
    logic [7:0]       st_byte;
    logic             do_store;
    logic             send;
    logic [CNT_W-1:0] cnt_edit;
    logic [CNT_W-1:0] cnt_after;
    logic [CNT_W-1:0] cnt_last;
    logic             commit;
    logic             load_byte;
    logic             load_empty;

    assign accept    = s_tvalid && s_tready;
    assign slot_free = !m_tvalid_reg || m_tready;
    assign at_last   = (rd_idx_reg == last_idx_reg);

    // Line editing of the incoming byte against the current fill count.
    always_comb begin
        st_byte  = in_char;
        do_store = 1'b0;
        send     = 1'b0;
        cnt_edit = fill_count_reg;
        if (in_char == CH_NUL) begin
            send = (fill_count_reg != '0) && !in_pend;
        end else if (raw_mode_reg) begin
            do_store = 1'b1;
            send     = !in_pend;
        end else begin
            if (in_char == CH_CR) begin
                st_byte = CH_LF;
            end
            case (st_byte)
                CH_BS: begin
                    if (fill_count_reg != '0) begin
                        cnt_edit = fill_count_reg - CNT_W'(1);
                    end
                end
                CH_KILL: begin
                    cnt_edit = '0;
                end
                CH_EOT: begin
                    send = 1'b1;
                end
                default: begin
                    do_store = 1'b1;
                    send     = (st_byte == CH_LF);
                end
            endcase
        end
        cnt_after = do_store ? cnt_edit + CNT_W'(1) : cnt_edit;
        cnt_last  = cnt_after - CNT_W'(1);
        commit    = send || (cnt_after == CNT_W'(LINE_LEN));
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && commit) begin
                    state_next = (cnt_after == '0) ? ST_EMPTY : ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                if (slot_free) begin
                    state_next = at_last ? ST_IDLE : ST_READ;
                end
            end
            ST_EMPTY: begin
                if (slot_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State outputs.
    always_comb begin
        s_tready   = 1'b0;
        ram_re     = 1'b0;
        load_byte  = 1'b0;
        load_empty = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
            end
            ST_READ: begin
                ram_re = 1'b1;
            end
            ST_LOAD: begin
                load_byte = slot_free;
            end
            ST_EMPTY: begin
                load_empty = slot_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    // Store port: bytes go in at the current fill position.
    assign ram_we    = accept && do_store;
    assign ram_waddr = fill_count_reg[IDX_W-1:0];
    assign ram_wdata = st_byte;
    assign ram_raddr = rd_idx_reg;

    // Counter and pointer updates.
    always_comb begin
        fill_count_next = fill_count_reg;
        rd_idx_next     = rd_idx_reg;
        last_idx_next   = last_idx_reg;
        if (accept) begin
            fill_count_next = commit ? '0 : cnt_after;
            if (commit) begin
                rd_idx_next   = '0;
                last_idx_next = cnt_last[IDX_W-1:0];
            end
        end
        if (load_byte && !at_last) begin
            rd_idx_next = rd_idx_reg + IDX_W'(1);
        end
    end

    // Output beat valid.
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (load_byte || load_empty) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            raw_mode_reg   <= 1'b0;
            fill_count_reg <= '0;
            rd_idx_reg     <= '0;
            last_idx_reg   <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            fill_count_reg <= fill_count_next;
            rd_idx_reg     <= rd_idx_next;
            last_idx_reg   <= last_idx_next;
            m_tvalid_reg   <= m_tvalid_next;
            if (cfg_we) begin
                raw_mode_reg <= cfg_wdata;
            end
        end
    end

    // Output beat payload.
    always_ff @(posedge aclk) begin
        if (load_byte) begin
            m_tdata_reg <= ram_rdata;
            m_tuser_reg <= 1'b0;
            m_tlast_reg <= at_last;
        end else if (load_empty) begin
            m_tdata_reg <= CH_NUL;
            m_tuser_reg <= 1'b1;
            m_tlast_reg <= 1'b1;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

    // The count stays below the store depth between items.
    `CLE_ASSERT_ALWAYS(a_fill_bound, aclk, aresetn, fill_count_reg < CNT_W'(LINE_LEN), "fill count reached store depth")
    // A commit in progress has already cleared the fill count.
    `CLE_ASSERT_IMPLY(a_commit_clear, aclk, aresetn, state_reg != ST_IDLE, fill_count_reg == '0, "fill count not cleared during commit")
    // The read pointer never runs past the last stored byte.
    `CLE_ASSERT_IMPLY(a_rd_bound, aclk, aresetn, state_reg == ST_LOAD, rd_idx_reg <= last_idx_reg, "read pointer beyond line end")
    // An empty-line beat is always the last of its line.
    `CLE_ASSERT_IMPLY(a_empty_last, aclk, aresetn, m_tvalid_reg && m_tuser_reg, m_tlast_reg && (m_tdata_reg == CH_NUL), "empty-line beat malformed")

endmodule

/* rtl/core/console_line_editor.sv */
`timescale 1ns / 1ps
// Console line editor. Each input beat carries one console byte and a flag
// saying more input is already waiting; the block gathers bytes into a line
// store and, on a commit (newline, end of file, flush, raw mode with nothing
// pending, or a full store), sends the line out one byte per beat with tlast
// on the final byte, or a single beat with tuser set for an empty line.
// An input beat that does not commit leaves the block idle, so such beats can
// be taken on every cycle. A commit keeps s_tready low until its last beat is
// loaded, each byte passing a read and a load state, as the line store has a
// single read port and registered read data; the last byte waits in the output
// register while new input is already taken. The user must write raw_mode
// through cfg_we and cfg_wdata only while the block is idle; it is not enforced.
module console_line_editor #(
    parameter int LINE_LEN = cle_pkg::LINE_LEN_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_wdata,   // raw_mode
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,     // [7:0] char_in, [8] more_pending, [15:9] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,     // [7:0] line_byte
    output logic        m_tlast,     // last_of_line
    output logic        m_tuser      // [0] empty_line
);

    localparam int IDX_W = $clog2(LINE_LEN);
    localparam int CNT_W = $clog2(LINE_LEN + 1);

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [7:0]       ram_wdata;
    logic             ram_re;
    logic [IDX_W-1:0] ram_raddr;
    logic [7:0]       ram_rdata;

    // Editing, commit sequencing and output register.
    cle_ctrl #(
        .LINE_LEN (LINE_LEN),
        .IDX_W    (IDX_W),
        .CNT_W    (CNT_W)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .in_char   (s_tdata[7:0]),
        .in_pend   (s_tdata[8]),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    // Line store.
    cle_line_ram #(
        .LINE_LEN (LINE_LEN),
        .IDX_W    (IDX_W)
    ) u_line_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

endmodule
